>>> hdl/cttu_pkg.sv
`timescale 1ns / 1ps

package cttu_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd10;
    localparam logic [15:0] RELOAD_RST      = 16'd1000;
    localparam logic [15:0] NO_WAKEUP       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE  = 2'd2;

    localparam logic [2:0] MODE_ACCEPT  = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_RETX    = 3'd2;
    localparam logic [2:0] MODE_TICK    = 3'd3;
    localparam logic [2:0] MODE_DELETE  = 3'd4;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_HELD      = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_RETX      = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_TICK_DONE = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] source_node;
        logic [31:0] seq_number;
        logic [31:0] creation_time;
        logic [31:0] fragment_offset;
        logic [15:0] bundle_number;
        logic        storage_has_space;
        logic [31:0] custodian_node;
        logic [15:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic [4:0]  max_entries;
        logic [15:0] reload;
        logic [31:0] local_node;
    } t_cfg;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] seq;
        logic [31:0] tim;
        logic [31:0] frag;
        logic [15:0] num;
        logic [15:0] cnt;
    } t_entry;

    typedef struct packed {
        logic        strobe;
        logic [2:0]  status;
        logic [15:0] num;
        logic        ack;
        logic [15:0] wake;
        logic        last;
    } t_res;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_qhs;

endpackage

>>> hdl/cttu_front.sv
`timescale 1ns / 1ps

module cttu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cttu_pkg::t_cmd i_cmd,
    output logic          o_busy,
    input  logic          i_back_ready,
    output cttu_pkg::t_qhs o_hs,
    output cttu_pkg::t_cmd o_cmd
);

    cttu_pkg::t_cmd r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;
    logic       push, pop, known;

    // drop modes that mean nothing here
    always_comb begin
        known = i_cmd.mode inside {cttu_pkg::MODE_ACCEPT, cttu_pkg::MODE_RELEASE,
                                   cttu_pkg::MODE_RETX, cttu_pkg::MODE_TICK,
                                   cttu_pkg::MODE_DELETE};
    end

    assign o_busy   = (r_fill == 2'd2);
    assign push     = i_start && !o_busy && known;
    assign pop      = (r_fill != 2'd0) && i_back_ready;
    assign o_hs     = '{valid: (r_fill != 2'd0), ready: i_back_ready};
    assign o_cmd    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr_ptr] <= i_cmd;
    end

endmodule

>>> hdl/cttu_back.sv
`timescale 1ns / 1ps

module cttu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cttu_pkg::t_cfg i_cfg,
    input  cttu_pkg::t_qhs i_hs,
    input  cttu_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output cttu_pkg::t_res o_res
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN} t_state;

    t_state                      r_state, n_state;
    cttu_pkg::t_cmd              r_cmd, n_cmd;
    logic [cttu_pkg::CNT_W-1:0]  r_idx, n_idx, r_count, n_count;
    logic [15:0]                 r_least, n_least;
    logic                        r_hit, n_hit;
    cttu_pkg::t_res              r_res, n_res;
    cttu_pkg::t_entry            r_ent [cttu_pkg::TABLE_ENTRIES];

    cttu_pkg::t_entry            cur, wr_data;
    logic                        wr_en, rm_en, key_hit, refuse;
    logic [cttu_pkg::IDX_W-1:0]  wr_idx, rm_idx;
    logic [15:0]                 dec;

    assign o_ready = (r_state == S_IDLE);
    assign o_res   = r_res;
    assign cur     = r_ent[r_idx[cttu_pkg::IDX_W-1:0]];
    assign key_hit = (cur.src == r_cmd.source_node) && (cur.seq == r_cmd.seq_number)
                  && (cur.tim == r_cmd.creation_time) && (cur.frag == r_cmd.fragment_offset);
    assign dec     = cur.cnt - r_cmd.elapsed;
    assign refuse  = !i_cmd.storage_has_space
                  || (32'(r_count) >= 32'(i_cfg.max_entries))
                  || (32'(r_count) >= 32'(cttu_pkg::TABLE_ENTRIES))
                  || ((i_cmd.source_node == i_cfg.local_node)
                      && (i_cmd.custodian_node != i_cfg.local_node));

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_count = r_count;
        n_least = r_least;
        n_hit   = r_hit;
        n_res   = '0;
        wr_en   = 1'b0;
        rm_en   = 1'b0;
        wr_idx  = r_idx[cttu_pkg::IDX_W-1:0];
        rm_idx  = r_idx[cttu_pkg::IDX_W-1:0];
        wr_data = cur;
        case (r_state)
            S_IDLE: begin
                if (i_hs.valid && i_hs.ready) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_least = cttu_pkg::NO_WAKEUP;
                    n_hit   = 1'b0;
                    if (i_cmd.mode == cttu_pkg::MODE_ACCEPT && refuse) begin
                        n_res = '{strobe: 1'b1, status: cttu_pkg::ST_REFUSED, num: 16'd0,
                                  ack: 1'b0, wake: 16'd0, last: 1'b1};
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = S_IDLE;
                    n_res   = '{strobe: 1'b1, status: cttu_pkg::ST_NOT_FOUND, num: 16'd0,
                                ack: 1'b0, wake: 16'd0, last: 1'b1};
                    case (r_cmd.mode)
                        cttu_pkg::MODE_ACCEPT: begin
                            // append behind the packed entries
                            wr_en   = 1'b1;
                            wr_idx  = r_count[cttu_pkg::IDX_W-1:0];
                            wr_data = '{src: r_cmd.source_node, seq: r_cmd.seq_number,
                                        tim: r_cmd.creation_time,
                                        frag: r_cmd.fragment_offset,
                                        num: r_cmd.bundle_number, cnt: i_cfg.reload};
                            n_count = r_count + 1'b1;
                            n_res.status = cttu_pkg::ST_ACCEPTED;
                            n_res.num    = r_cmd.bundle_number;
                            n_res.ack    = (r_cmd.source_node != i_cfg.local_node);
                        end
                        cttu_pkg::MODE_TICK: begin
                            n_res.status = cttu_pkg::ST_TICK_DONE;
                            n_res.wake   = r_least;
                        end
                        cttu_pkg::MODE_DELETE: begin
                            n_res.status = r_hit ? cttu_pkg::ST_RELEASED : cttu_pkg::ST_NOT_FOUND;
                            n_res.num    = r_cmd.bundle_number;
                        end
                        default: ;
                    endcase
                end else begin
                    n_idx = r_idx + 1'b1;
                    case (r_cmd.mode)
                        cttu_pkg::MODE_ACCEPT: begin
                            if (cur.num == r_cmd.bundle_number) begin
                                n_state = S_IDLE;
                                n_res   = '{strobe: 1'b1, status: cttu_pkg::ST_HELD,
                                            num: r_cmd.bundle_number, ack: 1'b0,
                                            wake: 16'd0, last: 1'b1};
                            end
                        end
                        cttu_pkg::MODE_RELEASE, cttu_pkg::MODE_RETX: begin
                            if (key_hit) begin
                                n_state = S_IDLE;
                                n_res   = '{strobe: 1'b1, status: cttu_pkg::ST_RETX,
                                            num: cur.num, ack: 1'b0, wake: 16'd0,
                                            last: 1'b1};
                                if (r_cmd.mode == cttu_pkg::MODE_RELEASE) begin
                                    rm_en        = 1'b1;
                                    n_count      = r_count - 1'b1;
                                    n_res.status = cttu_pkg::ST_RELEASED;
                                end else begin
                                    wr_en       = 1'b1;
                                    wr_data.cnt = i_cfg.reload;
                                end
                            end
                        end
                        cttu_pkg::MODE_TICK: begin
                            wr_en = 1'b1;
                            if (cur.cnt <= r_cmd.elapsed) begin
                                wr_data.cnt = i_cfg.reload;
                                n_res = '{strobe: 1'b1, status: cttu_pkg::ST_RETX,
                                          num: cur.num, ack: 1'b0, wake: 16'd0, last: 1'b0};
                            end else begin
                                wr_data.cnt = dec;
                                if (dec < r_least) n_least = dec;
                            end
                        end
                        cttu_pkg::MODE_DELETE: begin
                            // hold the index: the next entry slides into this slot
                            if (cur.num == r_cmd.bundle_number) begin
                                rm_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                n_hit   = 1'b1;
                                n_idx   = r_idx;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_least <= cttu_pkg::NO_WAKEUP;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_hit   <= n_hit;
            r_least <= n_least;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < cttu_pkg::TABLE_ENTRIES; j++) begin
            if (wr_en && wr_idx == cttu_pkg::IDX_W'(j)) begin
                r_ent[j] <= wr_data;
            end else if (rm_en && j < cttu_pkg::TABLE_ENTRIES - 1
                         && cttu_pkg::IDX_W'(j) >= rm_idx) begin
                r_ent[j] <= r_ent[(j + 1) % cttu_pkg::TABLE_ENTRIES];
            end
        end
    end

endmodule

>>> hdl/custody_table_with_retransmit_timers_unit.sv
`timescale 1ns / 1ps
// Custody table with retransmit timers.
// Input channel: drive the command fields with start high; the command is
// transferred at a clock edge where start is high and busy is low. A
// two-deep command queue sits in front of the table sequencer, so busy
// rises only when two commands are waiting.
// Result channel: o_strobe marks each result for exactly one cycle; o_last
// flags the final result of a command. The receiver cannot stall.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; 0 max entries, 1 reload,
// 2 local node id. Write only while no command is in flight.
// Sequencing: a refused accept answers without a table walk. Other commands
// walk the packed table one entry per cycle; a tick emits one retransmit per
// expired entry as it walks, then the tick done result.
// Reset clears the queue, the sequencer and the entry count (empty table)
// and loads register defaults 10, 1000 and 0.
module custody_table_with_retransmit_timers_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_source_node,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_creation_time,
    input  logic [31:0] i_fragment_offset,
    input  logic [15:0] i_bundle_number,
    input  logic        i_storage_has_space,
    input  logic [31:0] i_custodian_node,
    input  logic [15:0] i_elapsed,
    input  logic                           i_cfg_we,
    input  logic [cttu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cttu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_bundle_number,
    output logic        o_send_custody_ack,
    output logic [15:0] o_next_wakeup,
    output logic        o_last
);

    cttu_pkg::t_cfg r_cfg;
    cttu_pkg::t_cmd in_cmd, q_cmd;
    cttu_pkg::t_qhs q_hs;
    cttu_pkg::t_res res;
    logic           back_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{max_entries: cttu_pkg::MAX_ENTRIES_RST, reload: cttu_pkg::RELOAD_RST,
                       local_node: 32'd0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cttu_pkg::CFG_MAX_ENTRIES: r_cfg.max_entries <= i_cfg_data[4:0];
                cttu_pkg::CFG_RELOAD:      r_cfg.reload      <= i_cfg_data[15:0];
                cttu_pkg::CFG_LOCAL_NODE:  r_cfg.local_node  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign in_cmd = '{mode: i_mode, source_node: i_source_node, seq_number: i_seq_number,
                      creation_time: i_creation_time, fragment_offset: i_fragment_offset,
                      bundle_number: i_bundle_number,
                      storage_has_space: i_storage_has_space,
                      custodian_node: i_custodian_node, elapsed: i_elapsed};

    // front: transfer and classify, queue for the sequencer
    cttu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (in_cmd),
        .o_busy       (busy),
        .i_back_ready (back_ready),
        .o_hs         (q_hs),
        .o_cmd        (q_cmd)
    );

    // back: walk the table and emit results
    cttu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hs    (q_hs),
        .i_cmd   (q_cmd),
        .o_ready (back_ready),
        .o_res   (res)
    );

    assign o_strobe            = res.strobe;
    assign o_status            = res.status;
    assign o_out_bundle_number = res.num;
    assign o_send_custody_ack  = res.ack;
    assign o_next_wakeup       = res.wake;
    assign o_last              = res.last;

endmodule

>>> hdl/cttu_checker.sv
`timescale 1ns / 1ps

module cttu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic        o_send_custody_ack,
    input logic [15:0] o_next_wakeup,
    input logic        o_last
);

    // flags appear only on a live result
    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_last) else $error("last without strobe");

    a_ack_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_send_custody_ack |-> (o_strobe && o_status == cttu_pkg::ST_ACCEPTED))
        else $error("ack on wrong result");

    a_wake_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != cttu_pkg::ST_TICK_DONE) |-> (o_next_wakeup == 16'd0))
        else $error("wakeup on non-tick result");

    a_single_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != cttu_pkg::ST_RETX && o_status != cttu_pkg::ST_TICK_DONE)
        |-> o_last) else $error("single result not last");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe) else $error("result right after reset");

endmodule

bind custody_table_with_retransmit_timers_unit cttu_checker u_cttu_checker (.*);
